[rtl/efbd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efbd_pkg
// Shared widths, register indexes, reset values and the command and status
// bundles that join the beat detector controller and its datapath.
// ----------------------------------------------------------------------------
package efbd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int MAX_HOP    = 4096;
    localparam int MAX_RADIUS = 16;

    localparam int HOP_W      = 13;
    localparam int RAD_W      = 5;
    localparam int SENS_W     = 12;
    localparam int DEB_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int CNT_W      = 12;
    localparam int ENERGY_W   = 43;
    localparam int FRAME_W    = 24;
    localparam int CENTER_W   = 36;

    // Ring of recent flux values: two windows of radius plus the neighbors.
    localparam int LINE_LEN   = 2 * MAX_RADIUS + 2;
    localparam int LINE_AW    = $clog2(LINE_LEN);
    localparam int SPAN_MAX   = LINE_LEN - 2;

    localparam int SUM_W      = ENERGY_W + LINE_AW;
    localparam int LHS_W      = ENERGY_W + LINE_AW;
    localparam int THR_FRAC   = 8;
    localparam int RHS_W      = SUM_W + SENS_W;
    localparam int PROD_W     = FRAME_W + HOP_W;

    localparam logic [CFG_IDX_W-1:0] REG_HOP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd3;

    localparam logic [HOP_W-1:0]  HOP_RESET      = 13'd480;
    localparam logic [RAD_W-1:0]  RADIUS_RESET   = 5'd10;
    localparam logic [SENS_W-1:0] SENS_RESET     = 12'd384;
    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 20'd14400;

    localparam logic KIND_BEAT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic take_in;
        logic square;
        logic accum;
        logic close;
        logic flush_init;
        logic dec_setup;
        logic rd_issue;
        logic mul;
        logic test;
        logic emit_beat;
        logic emit_mark;
        logic d_dec;
    } efbd_cmd_t;

    typedef struct packed {
        logic close_due;
        logic last;
        logic decide_due;
        logic flush_none;
        logic rd_last;
        logic pass;
        logic d_one;
        logic out_free;
    } efbd_stat_t;

endpackage
`default_nettype wire

[rtl/efbd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efbd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module efbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/efbd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efbd_ctrl
// Sequencer for the beat detector: sample accumulation, frame close, the
// window decision of one frame and the end-of-stream flush.
// ----------------------------------------------------------------------------
module efbd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire efbd_pkg::efbd_stat_t stat,
    output efbd_pkg::efbd_cmd_t       cmd
);

    typedef enum logic [12:0] {
        ST_IDLE       = 13'b0000000000001,
        ST_SQUARE     = 13'b0000000000010,
        ST_ACCUM      = 13'b0000000000100,
        ST_CLOSE      = 13'b0000000001000,
        ST_FLUSH_INIT = 13'b0000000010000,
        ST_DEC_SETUP  = 13'b0000000100000,
        ST_DEC_READ   = 13'b0000001000000,
        ST_DEC_DRAIN  = 13'b0000010000000,
        ST_DEC_MUL    = 13'b0000100000000,
        ST_DEC_TEST   = 13'b0001000000000,
        ST_DEC_EMIT   = 13'b0010000000000,
        ST_DEC_END    = 13'b0100000000000,
        ST_MARK       = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   flushing_reg;
    logic   flushing_next;

    always_comb
    begin
        state_next    = state_reg;
        flushing_next = flushing_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = stat.close_due ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE:
            begin
                cmd.close     = 1'b1;
                flushing_next = 1'b0;
                if (stat.decide_due)
                begin
                    state_next = ST_DEC_SETUP;
                end
                else if (stat.last)
                begin
                    state_next = ST_FLUSH_INIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH_INIT:
            begin
                cmd.flush_init = 1'b1;
                flushing_next  = 1'b1;
                state_next     = stat.flush_none ? ST_MARK : ST_DEC_SETUP;
            end
            ST_DEC_SETUP:
            begin
                cmd.dec_setup = 1'b1;
                state_next    = ST_DEC_READ;
            end
            ST_DEC_READ:
            begin
                cmd.rd_issue = 1'b1;
                if (stat.rd_last)
                begin
                    state_next = ST_DEC_DRAIN;
                end
            end
            ST_DEC_DRAIN:
            begin
                state_next = ST_DEC_MUL;
            end
            ST_DEC_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DEC_TEST;
            end
            ST_DEC_TEST:
            begin
                cmd.test   = 1'b1;
                state_next = stat.pass ? ST_DEC_EMIT : ST_DEC_END;
            end
            ST_DEC_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_beat = 1'b1;
                    state_next    = ST_DEC_END;
                end
            end
            ST_DEC_END:
            begin
                if (flushing_reg)
                begin
                    if (stat.d_one)
                    begin
                        state_next = ST_MARK;
                    end
                    else
                    begin
                        cmd.d_dec  = 1'b1;
                        state_next = ST_DEC_SETUP;
                    end
                end
                else if (stat.last)
                begin
                    state_next = ST_FLUSH_INIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_mark = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            flushing_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            flushing_reg <= flushing_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

[rtl/efbd_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efbd_datapath
// Configuration registers, frame energy and flux state, window sum and
// threshold arithmetic, and the result register of the beat detector.
// ----------------------------------------------------------------------------
module efbd_datapath (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      cfg_we,
    input  wire logic [efbd_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [efbd_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  wire logic signed [efbd_pkg::SAMPLE_W-1:0]      sample,
    input  wire logic                                      last,
    input  wire efbd_pkg::efbd_cmd_t                       cmd,
    output efbd_pkg::efbd_stat_t                           stat,
    input  wire logic                                      out_ready,
    output logic                                           out_valid,
    output logic                                           kind,
    output logic [efbd_pkg::FRAME_W-1:0]                   beat_frame,
    output logic [efbd_pkg::CENTER_W-1:0]                  beat_center,
    output logic                                           final_res,
    output logic                                           ram_we,
    output logic [efbd_pkg::LINE_AW-1:0]                   ram_waddr,
    output logic [efbd_pkg::ENERGY_W-1:0]                  ram_wdata,
    output logic [efbd_pkg::LINE_AW-1:0]                   ram_raddr,
    input  wire logic [efbd_pkg::ENERGY_W-1:0]             ram_rdata
);

    localparam logic [efbd_pkg::LINE_AW-1:0] RD_CUR  = 6'd0;
    localparam logic [efbd_pkg::LINE_AW-1:0] RD_PREV = 6'd1;
    localparam logic [efbd_pkg::LINE_AW-1:0] RD_NEXT = 6'd2;
    localparam logic [efbd_pkg::LINE_AW-1:0] RD_SUM0 = 6'd3;

    // Configuration.
    logic [efbd_pkg::HOP_W-1:0]      hop_reg;
    logic [efbd_pkg::RAD_W-1:0]      radius_reg;
    logic [efbd_pkg::SENS_W-1:0]     sens_reg;
    logic [efbd_pkg::DEB_W-1:0]      deb_reg;
    logic [efbd_pkg::HOP_W-1:0]      hop_eff;
    logic [efbd_pkg::RAD_W-1:0]      rad_eff;

    // Sample path.
    logic signed [efbd_pkg::SAMPLE_W-1:0] sample_reg;
    logic                            last_reg;
    logic [efbd_pkg::SAMPLE_W-1:0]   raw;
    logic [efbd_pkg::SAMPLE_W-1:0]   mag;
    logic [efbd_pkg::SQ_W-1:0]       sq_reg;
    logic [efbd_pkg::CNT_W:0]        cnt_next;

    // Stream state.
    logic [efbd_pkg::ENERGY_W-1:0]   energy_reg;
    logic [efbd_pkg::ENERGY_W-1:0]   prev_reg;
    logic [efbd_pkg::CNT_W-1:0]      sif_reg;
    logic [efbd_pkg::FRAME_W-1:0]    frame_reg;
    logic [efbd_pkg::LINE_AW-1:0]    head_reg;
    logic [efbd_pkg::LINE_LEN-1:0]   valid_reg;
    logic [efbd_pkg::FRAME_W-1:0]    last_beat_reg;
    logic                            seen_reg;
    logic [efbd_pkg::ENERGY_W-1:0]   flux_new;

    // Decision of one frame.
    logic [efbd_pkg::FRAME_W-1:0]    j_reg;
    logic [efbd_pkg::RAD_W-1:0]      d_reg;
    logic [efbd_pkg::FRAME_W-1:0]    k_reg;
    logic [efbd_pkg::LINE_AW-1:0]    span_reg;
    logic [efbd_pkg::LINE_AW-1:0]    rd_idx_reg;
    logic [efbd_pkg::LINE_AW-1:0]    rd_idx_q_reg;
    logic                            rd_pend_reg;
    logic                            vld_q_reg;
    logic [efbd_pkg::ENERGY_W-1:0]   f_cur_reg;
    logic [efbd_pkg::ENERGY_W-1:0]   f_prev_reg;
    logic [efbd_pkg::ENERGY_W-1:0]   f_next_reg;
    logic [efbd_pkg::SUM_W-1:0]      sum_reg;
    logic [efbd_pkg::LHS_W-1:0]      lhs_reg;
    logic [efbd_pkg::RHS_W-1:0]      rhs_reg;
    logic [efbd_pkg::PROD_W-1:0]     prod_reg;

    logic [efbd_pkg::FRAME_W-1:0]    rad_ext;
    logic [efbd_pkg::FRAME_W-1:0]    j_flush;
    logic [efbd_pkg::RAD_W-1:0]      top0;
    logic [efbd_pkg::RAD_W-1:0]      top;
    logic [efbd_pkg::FRAME_W-1:0]    k_new;
    logic [efbd_pkg::FRAME_W-1:0]    lo;
    logic [efbd_pkg::FRAME_W-1:0]    span_full;
    logic [efbd_pkg::LINE_AW-1:0]    span_new;
    logic [efbd_pkg::LINE_AW-1:0]    rd_off;
    logic [efbd_pkg::LINE_AW:0]      addr_raw;
    logic [efbd_pkg::LINE_AW-1:0]    rd_addr;
    logic [efbd_pkg::ENERGY_W-1:0]   flux_rd;
    logic [efbd_pkg::LINE_AW-1:0]    span_plus;
    logic [efbd_pkg::FRAME_W-1:0]    mul_a;
    logic [efbd_pkg::RHS_W-1:0]      lhs_scaled;
    logic                            thr_ok;
    logic                            peak_ok;
    logic                            gap_ok;

    // Result register.
    logic                            out_valid_reg;
    logic                            kind_reg;
    logic [efbd_pkg::FRAME_W-1:0]    frame_out_reg;
    logic [efbd_pkg::CENTER_W-1:0]   center_out_reg;
    logic                            final_reg;
    logic                            out_free;

    // Out-of-range hop and radius settings are clamped into range.
    always_comb
    begin
        if (hop_reg == '0)
        begin
            hop_eff = efbd_pkg::HOP_W'(1);
        end
        else if (hop_reg > efbd_pkg::HOP_W'(efbd_pkg::MAX_HOP))
        begin
            hop_eff = efbd_pkg::HOP_W'(efbd_pkg::MAX_HOP);
        end
        else
        begin
            hop_eff = hop_reg;
        end
        if (radius_reg == '0)
        begin
            rad_eff = efbd_pkg::RAD_W'(1);
        end
        else if (radius_reg > efbd_pkg::RAD_W'(efbd_pkg::MAX_RADIUS))
        begin
            rad_eff = efbd_pkg::RAD_W'(efbd_pkg::MAX_RADIUS);
        end
        else
        begin
            rad_eff = radius_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_reg    <= efbd_pkg::HOP_RESET;
            radius_reg <= efbd_pkg::RADIUS_RESET;
            sens_reg   <= efbd_pkg::SENS_RESET;
            deb_reg    <= efbd_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                efbd_pkg::REG_HOP:      hop_reg    <= cfg_data[efbd_pkg::HOP_W-1:0];
                efbd_pkg::REG_RADIUS:   radius_reg <= cfg_data[efbd_pkg::RAD_W-1:0];
                efbd_pkg::REG_SENS:     sens_reg   <= cfg_data[efbd_pkg::SENS_W-1:0];
                efbd_pkg::REG_DEBOUNCE: deb_reg    <= cfg_data[efbd_pkg::DEB_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Magnitude of a two's complement sample; the most negative code maps to
    // its unsigned magnitude.
    assign raw      = sample_reg;
    assign mag      = raw[efbd_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
    assign cnt_next = {1'b0, sif_reg} + 1'b1;
    assign flux_new = ((frame_reg != '0) && (energy_reg > prev_reg))
                    ? (energy_reg - prev_reg) : '0;

    // Flush: the newest frame and the deepest pending decision.
    assign rad_ext = efbd_pkg::FRAME_W'(rad_eff);
    assign j_flush = frame_reg - 1'b1;
    assign top0    = rad_eff - 1'b1;
    always_comb
    begin
        if (j_flush == '0)
        begin
            top = '0;
        end
        else if (efbd_pkg::FRAME_W'(top0) > (j_flush - 1'b1))
        begin
            top = efbd_pkg::RAD_W'(j_flush - 1'b1);
        end
        else
        begin
            top = top0;
        end
    end

    // Window of the frame under decision, clipped at the stream start and to
    // the depth of the flux ring.
    assign k_new     = j_reg - efbd_pkg::FRAME_W'(d_reg);
    assign lo        = (k_new >= rad_ext) ? (k_new - rad_ext) : '0;
    assign span_full = j_reg - lo;
    assign span_new  = (span_full > efbd_pkg::FRAME_W'(efbd_pkg::SPAN_MAX))
                     ? efbd_pkg::LINE_AW'(efbd_pkg::SPAN_MAX)
                     : span_full[efbd_pkg::LINE_AW-1:0];

    // Read order: the frame itself, its older and newer neighbors, then the
    // window from the newest frame backward.
    always_comb
    begin
        case (rd_idx_reg)
            RD_CUR:  rd_off = efbd_pkg::LINE_AW'(d_reg);
            RD_PREV: rd_off = efbd_pkg::LINE_AW'(d_reg) + 1'b1;
            RD_NEXT: rd_off = efbd_pkg::LINE_AW'(d_reg) - 1'b1;
            default: rd_off = rd_idx_reg - RD_SUM0;
        endcase
    end

    assign addr_raw = {1'b0, head_reg} + (efbd_pkg::LINE_AW + 1)'(efbd_pkg::LINE_LEN - 1)
                    - {1'b0, rd_off};
    assign rd_addr  = (addr_raw >= (efbd_pkg::LINE_AW + 1)'(efbd_pkg::LINE_LEN))
                    ? efbd_pkg::LINE_AW'(addr_raw - (efbd_pkg::LINE_AW + 1)'(efbd_pkg::LINE_LEN))
                    : addr_raw[efbd_pkg::LINE_AW-1:0];
    assign flux_rd  = vld_q_reg ? ram_rdata : '0;

    assign ram_we    = cmd.close;
    assign ram_waddr = head_reg;
    assign ram_wdata = flux_new;
    assign ram_raddr = rd_addr;

    assign span_plus  = span_reg + 1'b1;
    assign mul_a      = cmd.test ? k_reg : (k_reg - last_beat_reg);
    assign lhs_scaled = {{(efbd_pkg::RHS_W - efbd_pkg::LHS_W - efbd_pkg::THR_FRAC){1'b0}},
                         lhs_reg, {efbd_pkg::THR_FRAC{1'b0}}};
    assign thr_ok     = lhs_scaled > rhs_reg;
    assign peak_ok    = (f_cur_reg >= f_prev_reg) && (f_cur_reg > f_next_reg);
    assign gap_ok     = !seen_reg || (prod_reg >= efbd_pkg::PROD_W'(deb_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            sample_reg <= sample;
            last_reg   <= last;
        end
        if (cmd.square)
        begin
            sq_reg <= efbd_pkg::SQ_W'(mag) * efbd_pkg::SQ_W'(mag);
        end
        if (cmd.close)
        begin
            j_reg <= frame_reg;
            d_reg <= rad_eff;
        end
        if (cmd.flush_init)
        begin
            j_reg <= j_flush;
            d_reg <= top;
        end
        if (cmd.d_dec)
        begin
            d_reg <= d_reg - 1'b1;
        end
        if (cmd.dec_setup)
        begin
            k_reg    <= k_new;
            span_reg <= span_new;
        end
        if (cmd.rd_issue)
        begin
            rd_idx_q_reg <= rd_idx_reg;
            vld_q_reg    <= valid_reg[rd_addr];
        end
        if (cmd.dec_setup)
        begin
            sum_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            case (rd_idx_q_reg)
                RD_CUR:  f_cur_reg  <= flux_rd;
                RD_PREV: f_prev_reg <= flux_rd;
                RD_NEXT: f_next_reg <= flux_rd;
                default: sum_reg    <= sum_reg + efbd_pkg::SUM_W'(flux_rd);
            endcase
        end
        if (cmd.mul)
        begin
            lhs_reg <= efbd_pkg::LHS_W'(f_cur_reg) * efbd_pkg::LHS_W'(span_plus);
            rhs_reg <= efbd_pkg::RHS_W'(sum_reg) * efbd_pkg::RHS_W'(sens_reg);
        end
        if (cmd.mul || cmd.test)
        begin
            prod_reg <= efbd_pkg::PROD_W'(mul_a) * efbd_pkg::PROD_W'(hop_eff);
        end
        if (cmd.emit_beat)
        begin
            kind_reg       <= efbd_pkg::KIND_BEAT;
            frame_out_reg  <= k_reg;
            center_out_reg <= efbd_pkg::CENTER_W'(prod_reg)
                            + efbd_pkg::CENTER_W'(hop_eff >> 1);
            final_reg      <= !last_reg;
        end
        else if (cmd.emit_mark)
        begin
            kind_reg       <= efbd_pkg::KIND_END;
            frame_out_reg  <= '0;
            center_out_reg <= '0;
            final_reg      <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg    <= '0;
            prev_reg      <= '0;
            sif_reg       <= '0;
            frame_reg     <= '0;
            head_reg      <= '0;
            valid_reg     <= '0;
            last_beat_reg <= '0;
            seen_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_issue;
            if (cmd.accum)
            begin
                energy_reg <= energy_reg + efbd_pkg::ENERGY_W'(sq_reg);
                sif_reg    <= cnt_next[efbd_pkg::CNT_W-1:0];
            end
            if (cmd.close)
            begin
                valid_reg[head_reg] <= 1'b1;
                head_reg  <= (head_reg == efbd_pkg::LINE_AW'(efbd_pkg::LINE_LEN - 1))
                           ? '0 : head_reg + 1'b1;
                prev_reg   <= energy_reg;
                energy_reg <= '0;
                sif_reg    <= '0;
                frame_reg  <= frame_reg + 1'b1;
            end
            if (cmd.dec_setup)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.rd_issue)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmd.emit_beat)
            begin
                seen_reg      <= 1'b1;
                last_beat_reg <= k_reg;
            end
            // The end marker starts a fresh stream.
            if (cmd.emit_mark)
            begin
                energy_reg    <= '0;
                prev_reg      <= '0;
                sif_reg       <= '0;
                frame_reg     <= '0;
                head_reg      <= '0;
                valid_reg     <= '0;
                last_beat_reg <= '0;
                seen_reg      <= 1'b0;
            end
            if (cmd.emit_beat || cmd.emit_mark)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.close_due  = (cnt_next >= (efbd_pkg::CNT_W + 1)'(hop_eff)) || last_reg;
        stat.last       = last_reg;
        stat.decide_due = frame_reg >= (rad_ext + 1'b1);
        stat.flush_none = (top == '0);
        stat.rd_last    = (rd_idx_reg == (span_reg + RD_SUM0));
        stat.pass       = thr_ok && peak_ok && gap_ok;
        stat.d_one      = (d_reg == efbd_pkg::RAD_W'(1));
        stat.out_free   = out_free;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign beat_frame  = frame_out_reg;
    assign beat_center = center_out_reg;
    assign final_res   = final_reg;

endmodule
`default_nettype wire

[rtl/energy_flux_beat_detector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// energy_flux_beat_detector
// Energy-flux onset detector with an adaptive moving-average threshold.
// ----------------------------------------------------------------------------
// Samples enter one item at a time. A sample that closes a frame may also
// start the decision of one frame, with an emit step when a beat is emitted.
// The window of that frame reaches back at most 32 frames and is read from the
// flux memory one entry per cycle over its single read port. A sample with
// last set also starts the flush, decides up to radius - 1 pending frames in
// that way, over narrower windows, and then emits the end marker. A result
// waits in the output register, and the block stalls only when it must emit
// another result while that register is still full. No clearing pass runs
// after reset.
module energy_flux_beat_detector (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [efbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [efbd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [efbd_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                                 last,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      kind,
    output logic [efbd_pkg::FRAME_W-1:0]              beat_frame,
    output logic [efbd_pkg::CENTER_W-1:0]             beat_center,
    output logic                                      final_res
);

    efbd_pkg::efbd_cmd_t                  cmd;
    efbd_pkg::efbd_stat_t                 stat;
    logic                                 ram_we;
    logic [efbd_pkg::LINE_AW-1:0]         ram_waddr;
    logic [efbd_pkg::ENERGY_W-1:0]        ram_wdata;
    logic [efbd_pkg::LINE_AW-1:0]         ram_raddr;
    logic [efbd_pkg::ENERGY_W-1:0]        ram_rdata;

    efbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    efbd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .last        (last),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .kind        (kind),
        .beat_frame  (beat_frame),
        .beat_center (beat_center),
        .final_res   (final_res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // Ring of recent flux values.
    efbd_ram #(
        .WIDTH (efbd_pkg::ENERGY_W),
        .DEPTH (efbd_pkg::LINE_LEN)
    ) u_flux_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire
